// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("%m: assertion failed");

// Property checked on every edge, reset included.
`define ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ===== design/pbr1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr1_pkg
// Shared types and constants of the planar ByteRun1 decoder.
// ----------------------------------------------------------------------------
package pbr1_pkg;

    // parameter defaults
    localparam int DEF_MAX_PLANES    = 8;
    localparam int DEF_MAX_ROW_BYTES = 1024;
    localparam int DEF_MAX_ROWS      = 4096;

    // register field widths
    localparam int ROW_BYTES_W   = 11;
    localparam int ROW_TOTAL_W   = 13;
    localparam int PLANE_TOTAL_W = 4;

    // register map indexes (byte address = 4 * index)
    localparam logic [1:0] REG_ROW_BYTES   = 2'd0;
    localparam logic [1:0] REG_ROW_TOTAL   = 2'd1;
    localparam logic [1:0] REG_PLANE_TOTAL = 2'd2;
    localparam logic [1:0] REG_PACKED_MODE = 2'd3;

    // reset values
    localparam logic [ROW_BYTES_W-1:0]   RST_ROW_BYTES   = 11'd40;
    localparam logic [ROW_TOTAL_W-1:0]   RST_ROW_TOTAL   = 13'd200;
    localparam logic [PLANE_TOTAL_W-1:0] RST_PLANE_TOTAL = 4'd5;
    localparam logic                     RST_PACKED_MODE = 1'b1;

    // result status codes
    localparam logic ST_WRITE   = 1'b0;
    localparam logic ST_OVERRUN = 1'b1;

    // input op codes
    localparam logic OP_BODY  = 1'b0;
    localparam logic OP_START = 1'b1;

    // ByteRun1 no-op control code
    localparam logic [7:0] CODE_NOP = 8'd128;

    typedef struct packed {
        logic [ROW_BYTES_W-1:0]   row_bytes;
        logic [ROW_TOTAL_W-1:0]   row_total;
        logic [PLANE_TOTAL_W-1:0] plane_total;
        logic                     packed_mode;
    } cfg_t;

    typedef struct packed {
        logic        status;
        logic [2:0]  plane_index;
        logic [11:0] row_index;
        logic [9:0]  column;
        logic [7:0]  fill_value;
        logic [7:0]  repeat_res;
        logic        image_done;
    } res_t;

endpackage

// ===== design/pbr1_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr1_cfg
// APB register file holding the image geometry and body mode.
// ----------------------------------------------------------------------------
module pbr1_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output pbr1_pkg::cfg_t      cfg
);
    import pbr1_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_ROW_BYTES:   cfg_next.row_bytes   = pwdata[ROW_BYTES_W-1:0];
                REG_ROW_TOTAL:   cfg_next.row_total   = pwdata[ROW_TOTAL_W-1:0];
                REG_PLANE_TOTAL: cfg_next.plane_total = pwdata[PLANE_TOTAL_W-1:0];
                REG_PACKED_MODE: cfg_next.packed_mode = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_bytes   <= RST_ROW_BYTES;
            cfg_reg.row_total   <= RST_ROW_TOTAL;
            cfg_reg.plane_total <= RST_PLANE_TOTAL;
            cfg_reg.packed_mode <= RST_PACKED_MODE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROW_BYTES:   prdata = 32'(cfg_reg.row_bytes);
            REG_ROW_TOTAL:   prdata = 32'(cfg_reg.row_total);
            REG_PLANE_TOTAL: prdata = 32'(cfg_reg.plane_total);
            REG_PACKED_MODE: prdata = 32'(cfg_reg.packed_mode);
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/pbr1_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr1_core
// Decode state and combinational next-state / write-command logic.
// ----------------------------------------------------------------------------
module pbr1_core #(
    parameter int MAX_PLANES    = pbr1_pkg::DEF_MAX_PLANES,
    parameter int MAX_ROW_BYTES = pbr1_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS      = pbr1_pkg::DEF_MAX_ROWS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  logic            op,
    input  logic [7:0]      body_byte,
    input  pbr1_pkg::cfg_t  cfg,
    output logic            res_valid,
    output pbr1_pkg::res_t  res
);
    import pbr1_pkg::*;

    localparam int COL_W   = $clog2(MAX_ROW_BYTES);
    localparam int SUM_W   = ((COL_W > 8) ? COL_W : 8) + 1;
    localparam int RBC_W   = (ROW_BYTES_W > SUM_W) ? ROW_BYTES_W : SUM_W;
    localparam int PLANE_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PT_W    = PLANE_W + 1;
    localparam int PTC_W   = (PLANE_TOTAL_W > PT_W) ? PLANE_TOTAL_W : PT_W;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RT_W    = ROW_W + 1;
    localparam int RTC_W   = (ROW_TOTAL_W > RT_W) ? ROW_TOTAL_W : RT_W;

    // phase codes
    localparam logic [1:0] PH_CODE    = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_RUN     = 2'd2;

    logic [1:0]         phase_reg,  phase_next;
    logic [6:0]         lit_reg,    lit_next;
    logic [7:0]         run_reg,    run_next;
    logic [COL_W-1:0]   col_reg,    col_next;
    logic [PLANE_W-1:0] plane_reg,  plane_next;
    logic [ROW_W-1:0]   row_reg,    row_next;
    logic               halted_reg, halted_next;

    // clamped geometry
    logic [RBC_W-1:0]   rb_raw;
    logic [RBC_W-1:0]   rb_clamp;
    logic [SUM_W-1:0]   rb;
    logic [PTC_W-1:0]   pt_raw;
    logic [PTC_W-1:0]   pt_clamp;
    logic [PT_W-1:0]    pt;
    logic [RTC_W-1:0]   rt_raw;
    logic [RTC_W-1:0]   rt_clamp;
    logic [RT_W-1:0]    rt;

    always_comb begin
        rb_raw = RBC_W'(cfg.row_bytes);
        if (rb_raw == '0) begin
            rb_clamp = RBC_W'(1);
        end else if (rb_raw > RBC_W'(MAX_ROW_BYTES)) begin
            rb_clamp = RBC_W'(MAX_ROW_BYTES);
        end else begin
            rb_clamp = rb_raw;
        end
        rb = SUM_W'(rb_clamp);

        pt_raw = PTC_W'(cfg.plane_total);
        if (pt_raw == '0) begin
            pt_clamp = PTC_W'(1);
        end else if (pt_raw > PTC_W'(MAX_PLANES)) begin
            pt_clamp = PTC_W'(MAX_PLANES);
        end else begin
            pt_clamp = pt_raw;
        end
        pt = PT_W'(pt_clamp);

        rt_raw = RTC_W'(cfg.row_total);
        if (rt_raw == '0) begin
            rt_clamp = RTC_W'(1);
        end else if (rt_raw > RTC_W'(MAX_ROWS)) begin
            rt_clamp = RTC_W'(MAX_ROWS);
        end else begin
            rt_clamp = rt_raw;
        end
        rt = RT_W'(rt_clamp);
    end

    // byte count that the current byte asks for, checked against row end
    logic [7:0]       need_n;
    logic [SUM_W-1:0] need_end;
    logic             over_hit;

    always_comb begin
        case (phase_reg)
            PH_LITERAL: need_n = 8'd1;
            PH_RUN:     need_n = run_reg;
            default: begin
                if (body_byte[7]) begin
                    need_n = 8'(9'd257 - {1'b0, body_byte});
                end else begin
                    need_n = body_byte + 8'd1;
                end
            end
        endcase
        need_end = SUM_W'(col_reg) + SUM_W'(need_n);
        over_hit = need_end > rb;
    end

    // main step
    logic             do_wr;
    logic             do_over;
    logic [7:0]       wr_rep;
    logic [SUM_W-1:0] c_sum;
    logic [PT_W-1:0]  p_inc;
    logic [RT_W-1:0]  r_inc;
    logic             done;

    always_comb begin
        phase_next  = phase_reg;
        lit_next    = lit_reg;
        run_next    = run_reg;
        col_next    = col_reg;
        plane_next  = plane_reg;
        row_next    = row_reg;
        halted_next = halted_reg;
        do_wr       = 1'b0;
        do_over     = 1'b0;
        wr_rep      = 8'd1;
        done        = 1'b0;

        if (op == OP_START) begin
            phase_next  = PH_CODE;
            lit_next    = '0;
            run_next    = '0;
            col_next    = '0;
            plane_next  = '0;
            row_next    = '0;
            halted_next = 1'b0;
        end else if (!halted_reg) begin
            if (!cfg.packed_mode) begin
                phase_next = PH_CODE;
                do_wr      = 1'b1;
            end else begin
                case (phase_reg)
                    PH_LITERAL: begin
                        if (over_hit) begin
                            do_over = 1'b1;
                        end else begin
                            do_wr = 1'b1;
                            if (lit_reg == '0) begin
                                phase_next = PH_CODE;
                            end else begin
                                lit_next = lit_reg - 7'd1;
                            end
                        end
                    end
                    PH_RUN: begin
                        phase_next = PH_CODE;
                        wr_rep     = run_reg;
                        if (over_hit) begin
                            do_over = 1'b1;
                        end else begin
                            do_wr = 1'b1;
                        end
                    end
                    default: begin
                        if (body_byte != CODE_NOP) begin
                            if (over_hit) begin
                                do_over = 1'b1;
                            end else if (body_byte[7]) begin
                                run_next   = need_n;
                                phase_next = PH_RUN;
                            end else begin
                                lit_next   = body_byte[6:0];
                                phase_next = PH_LITERAL;
                            end
                        end
                    end
                endcase
            end
        end

        // position advance for a write
        c_sum = SUM_W'(col_reg) + SUM_W'(wr_rep);
        p_inc = PT_W'(plane_reg) + PT_W'(1);
        r_inc = RT_W'(row_reg) + RT_W'(1);
        if (do_wr) begin
            if (c_sum >= rb) begin
                col_next = '0;
                if (p_inc >= pt) begin
                    plane_next = '0;
                    if (r_inc >= rt) begin
                        done     = 1'b1;
                        row_next = '0;
                    end else begin
                        row_next = ROW_W'(r_inc);
                    end
                end else begin
                    plane_next = PLANE_W'(p_inc);
                end
            end else begin
                col_next = COL_W'(c_sum);
            end
            if (done) begin
                halted_next = 1'b1;
            end
        end
        if (do_over) begin
            halted_next = 1'b1;
            phase_next  = PH_CODE;
        end
    end

    always_comb begin
        res_valid       = do_wr | do_over;
        res.status      = do_over ? ST_OVERRUN : ST_WRITE;
        res.plane_index = 3'(plane_reg);
        res.row_index   = 12'(row_reg);
        res.column      = 10'(col_reg);
        res.fill_value  = do_over ? 8'd0 : body_byte;
        res.repeat_res  = do_over ? need_n : wr_rep;
        res.image_done  = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_CODE;
            lit_reg    <= '0;
            run_reg    <= '0;
            col_reg    <= '0;
            plane_reg  <= '0;
            row_reg    <= '0;
            halted_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            lit_reg    <= lit_next;
            run_reg    <= run_next;
            col_reg    <= col_next;
            plane_reg  <= plane_next;
            row_reg    <= row_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ===== design/planar_byterun1_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_byterun1_decoder
// Interleaved bitplane image body decoder (raw or ByteRun1) to write commands.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one body byte per transfer in s_tdata; s_tuser high marks a
//   start item, which clears the position and any error and gives no result.
//   m_ channel: at most one write command per input byte. m_tuser high marks
//   a row overrun error, after which bytes are dropped until a start item.
//   m_tlast flags the write that completes the last plane of the last row;
//   later bytes are dropped likewise.
//   APB port: row_bytes @0x0, row_total @0x4, plane_total @0x8,
//   packed_mode @0xC. Write only while the block is idle.
// Timing:
//   a byte goes into the input register at its transfer, is decoded once
//   the result register can take its outcome and its command is registered
//   there. One byte per cycle is sustained while m_tready stays high; the
//   next state of the decode loop (column, plane, row and phase) is combinational.
// Reset (aresetn low, synchronous): both stage registers empty, decode state
//   cleared, registers back to 40 / 200 / 5 / packed.
// Back-pressure: with m_tready low the result register holds; one more byte
//   is taken into the input register, then s_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module planar_byterun1_decoder #(
    parameter int MAX_PLANES    = pbr1_pkg::DEF_MAX_PLANES,
    parameter int MAX_ROW_BYTES = pbr1_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS      = pbr1_pkg::DEF_MAX_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] body_byte
    input  logic        s_tuser,    // [0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [2:0] plane_index, [14:3] row_index,
                                    // [24:15] column, [32:25] fill_value,
                                    // [40:33] repeat_res, [47:41] zero
    output logic        m_tuser,    // [0] status
    output logic        m_tlast,    // image_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pbr1_pkg::*;

    cfg_t       cfg;

    // input register
    logic       in_vld_reg, in_vld_next;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    // result register
    logic       out_vld_reg, out_vld_next;
    res_t       out_res_reg;

    logic       out_free;
    logic       advance;
    logic       s_xfer;
    logic       step_vld;
    res_t       step_res;

    pbr1_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the held byte is decoded when the result register can take its outcome
    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    pbr1_core #(
        .MAX_PLANES    (MAX_PLANES),
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .op        (in_op_reg),
        .body_byte (in_byte_reg),
        .cfg       (cfg),
        .res_valid (step_vld),
        .res       (step_res)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_xfer) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = step_vld;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance && step_vld) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tlast  = out_res_reg.image_done;
    assign m_tdata  = {7'd0,
                       out_res_reg.repeat_res,
                       out_res_reg.fill_value,
                       out_res_reg.column,
                       out_res_reg.row_index,
                       out_res_reg.plane_index};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // both stages come out of reset empty
    `ASSERT_ANY(a_reset_empty, aclk, !aresetn |=> !m_tvalid && !in_vld_reg)
    // input stage only blocks when a result is stuck at the output
    `ASSERT_RST(a_block_cause, aclk, aresetn,
        (in_vld_reg && !s_tready) |-> (m_tvalid && !m_tready))
    // an error never closes an image, and every command has a nonzero repeat count
    `ASSERT_RST(a_result_sane, aclk, aresetn,
        m_tvalid |-> (!(m_tuser && m_tlast) && (m_tdata[40:33] != 8'd0)))

endmodule

// ===== test/tb_planar_byterun1_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_byterun1_decoder
// Self-checking bench for the planar ByteRun1 body decoder. A write-command
// tracker mirrors the decode state and queues the command each accepted body
// byte should give; every result transfer is checked against the oldest one.
// Directed bytes cover the code classes, overruns, image completion and
// register changes mid-image. Random phases follow, each with new register
// settings and mostly well-formed packed streams.
// ----------------------------------------------------------------------------

class write_tracker;
    typedef enum logic [1:0] {PH_CODE, PH_LITERAL, PH_RUN} decode_phase_t;

    logic [10:0]   row_bytes;
    logic [12:0]   row_total;
    logic [3:0]    plane_total;
    logic          packed_mode;
    decode_phase_t phase;
    logic [6:0]    literal_left;
    int unsigned   run_length;
    int unsigned   column_pos;
    int unsigned   plane_pos;
    int unsigned   row_pos;
    bit            halted;
    pbr1_pkg::res_t pending_writes[$];
    int unsigned   mismatches;

    function new();
        row_bytes   = pbr1_pkg::RST_ROW_BYTES;
        row_total   = pbr1_pkg::RST_ROW_TOTAL;
        plane_total = pbr1_pkg::RST_PLANE_TOTAL;
        packed_mode = pbr1_pkg::RST_PACKED_MODE;
        mismatches  = 0;
        clear_image();
    endfunction

    function int unsigned clamp_to(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function int unsigned row_width();
        return clamp_to(32'(row_bytes), pbr1_pkg::DEF_MAX_ROW_BYTES);
    endfunction

    // bytes still free in the current plane row
    function int unsigned room_left();
        return (column_pos < row_width()) ? row_width() - column_pos : 0;
    endfunction

    function bit wants_code();
        return packed_mode && phase == PH_CODE;
    endfunction

    function void clear_image();
        phase        = PH_CODE;
        literal_left = '0;
        run_length   = 0;
        column_pos   = 0;
        plane_pos    = 0;
        row_pos      = 0;
        halted       = 1'b0;
    endfunction

    function void note_config(logic [1:0] idx, logic [31:0] value);
        case (idx)
            pbr1_pkg::REG_ROW_BYTES:   row_bytes   = value[10:0];
            pbr1_pkg::REG_ROW_TOTAL:   row_total   = value[12:0];
            pbr1_pkg::REG_PLANE_TOTAL: plane_total = value[3:0];
            pbr1_pkg::REG_PACKED_MODE: packed_mode = value[0];
            default: ;
        endcase
    endfunction

    function pbr1_pkg::res_t stamp(logic st, logic [7:0] val, int unsigned n, bit done);
        pbr1_pkg::res_t w;
        w.status      = st;
        w.plane_index = plane_pos[2:0];
        w.row_index   = row_pos[11:0];
        w.column      = column_pos[9:0];
        w.fill_value  = val;
        w.repeat_res  = n[7:0];
        w.image_done  = done;
        return w;
    endfunction

    function void queue_overrun(int unsigned n);
        pending_writes.push_back(stamp(pbr1_pkg::ST_OVERRUN, 8'h00, n, 1'b0));
        halted = 1'b1;
        phase  = PH_CODE;
    endfunction

    function void queue_write(logic [7:0] val, int unsigned n);
        int unsigned rb, pt, rt, c, p, r;
        bit done;
        rb = row_width();
        pt = clamp_to(32'(plane_total), pbr1_pkg::DEF_MAX_PLANES);
        rt = clamp_to(32'(row_total), pbr1_pkg::DEF_MAX_ROWS);
        c = column_pos + n;
        p = plane_pos;
        r = row_pos;
        done = 1'b0;
        if (c >= rb) begin
            c = 0;
            p++;
            if (p >= pt) begin
                p = 0;
                r++;
                if (r >= rt) begin
                    done = 1'b1;
                    r = 0;
                end
            end
        end
        pending_writes.push_back(stamp(pbr1_pkg::ST_WRITE, val, n, done));
        column_pos = c;
        plane_pos  = p;
        row_pos    = r;
        if (done) halted = 1'b1;
    endfunction

    // note an accepted input transfer and queue the command it causes
    function void take_byte(logic op, logic [7:0] b);
        int unsigned rb, n;
        rb = row_width();
        if (op == pbr1_pkg::OP_START) begin
            clear_image();
            return;
        end
        if (halted) return;
        if (!packed_mode) begin
            phase = PH_CODE;
            queue_write(b, 1);
            return;
        end
        case (phase)
            PH_LITERAL: begin
                if (column_pos + 1 > rb) begin
                    queue_overrun(1);
                end else begin
                    if (literal_left == 0) phase = PH_CODE;
                    else literal_left = literal_left - 7'd1;
                    queue_write(b, 1);
                end
            end
            PH_RUN: begin
                n = run_length;
                phase = PH_CODE;
                if (column_pos + n > rb) queue_overrun(n);
                else queue_write(b, n);
            end
            default: begin
                if (b == pbr1_pkg::CODE_NOP) return;
                n = (b < 8'h80) ? 32'(b) + 1 : 257 - 32'(b);
                if (column_pos + n > rb) begin
                    queue_overrun(n);
                end else if (b < 8'h80) begin
                    literal_left = b[6:0];
                    phase = PH_LITERAL;
                end else begin
                    run_length = n;
                    phase = PH_RUN;
                end
            end
        endcase
    endfunction

    function string describe(pbr1_pkg::res_t r);
        return $sformatf("st=%0d plane=%0d row=%0d col=%0d val=%02h rep=%0d done=%0d",
                         r.status, r.plane_index, r.row_index, r.column,
                         r.fill_value, r.repeat_res, r.image_done);
    endfunction

    // check one result transfer against the oldest queued command
    function void check_write(pbr1_pkg::res_t got);
        pbr1_pkg::res_t want;
        bit bad;
        if (pending_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with nothing expected: %s", describe(got));
            return;
        end
        want = pending_writes.pop_front();
        bad = (got.status !== want.status) || (got.plane_index !== want.plane_index) ||
              (got.row_index !== want.row_index) || (got.column !== want.column) ||
              (got.fill_value !== want.fill_value) ||
              (got.repeat_res !== want.repeat_res) || (got.image_done !== want.image_done);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result mismatch\n  expected %s\n  actual   %s",
                         describe(want), describe(got));
        end
    endfunction
endclass

module tb_planar_byterun1_decoder;
    import pbr1_pkg::*;

    localparam int         LONG_HOLD = 300;     // receiver hold-off, in cycles
    localparam int         SETTLE    = 6;       // input and result registers plus margin
    localparam int         PHASES    = 8;
    localparam int         PER_PHASE = 203;     // random bytes per phase

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;     // [7:0] body_byte
    logic        s_tuser  = 1'b0;      // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;              // [2:0] plane_index, [14:3] row_index,
                                       // [24:15] column, [32:25] fill_value,
                                       // [40:33] repeat_res, [47:41] zero
    logic        m_tuser;              // [0] status
    logic        m_tlast;              // image_done
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'h0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // knobs shared between the stimulus and the receiver
    bit sender_eager   = 1'b0;   // no gaps between input transfers
    bit receiver_eager = 1'b0;   // m_tready held high
    bit hold_request   = 1'b0;   // ask the receiver for one long hold-off

    write_tracker sb;

    planar_byterun1_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // -------------------------------------------------------------------------
    // Result side: ready is changed at the falling edge, transfers are taken
    // at the rising edge.
    // -------------------------------------------------------------------------
    initial begin : result_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                // long back-pressure so the block fills and stalls its input
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (!receiver_eager) stall_left = idle_gap();
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status      = m_tuser;
            got.plane_index = m_tdata[2:0];
            got.row_index   = m_tdata[14:3];
            got.column      = m_tdata[24:15];
            got.fill_value  = m_tdata[32:25];
            got.repeat_res  = m_tdata[40:33];
            got.image_done  = m_tlast;
            sb.check_write(got);
        end
    end

    // -------------------------------------------------------------------------
    // Input side and register port
    // -------------------------------------------------------------------------

    // one input transfer, after a random gap (none when sender_eager is set); valid stays up afterwards until
    // the next falling edge decides what comes next
    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = sender_eager ? 0 : idle_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(op, b);
    endtask

    // stop sending and let every queued command come out, plus the pipeline
    // time of any byte that gives no command
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending_writes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // setup cycle then access cycle; the register takes the write at the
    // rising edge where the access phase meets pready
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.note_config(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // settings for one random phase; the first three hit the extremes
    // (maximum, zero clamped up, over range clamped down)
    task automatic configure_phase(input int k);
        logic [10:0] rb;
        logic [12:0] rt;
        logic [3:0]  pt;
        logic        pm;
        case (k)
            0: begin
                rb = 11'd1024; rt = 13'd4096; pt = 4'd8; pm = 1'b1;
            end
            1: begin
                rb = 11'd0; rt = 13'd0; pt = 4'd0; pm = 1'b1;
            end
            2: begin
                rb = 11'd2047; rt = 13'd8191; pt = 4'd15; pm = 1'b0;
            end
            default: begin
                // small images mostly, so completion comes round often
                rb = ($urandom_range(0, 99) < 80) ? 11'($urandom_range(1, 12))
                                                  : 11'($urandom_range(0, 2047));
                rt = ($urandom_range(0, 99) < 80) ? 13'($urandom_range(1, 4))
                                                  : 13'($urandom_range(0, 8191));
                pt = 4'($urandom_range(0, 15));
                pm = ($urandom_range(0, 9) != 0);
            end
        endcase
        // upper data bits are random and must be ignored
        reg_write(REG_ROW_BYTES,   ($urandom() << 11) | 32'(rb));
        reg_write(REG_ROW_TOTAL,   ($urandom() << 13) | 32'(rt));
        reg_write(REG_PLANE_TOTAL, ($urandom() << 4)  | 32'(pt));
        reg_write(REG_PACKED_MODE, ($urandom() << 1)  | 32'(pm));
    endtask

    // next random byte: mostly a well-formed ByteRun1 stream that fits the
    // row, with some starts, noise, no-ops and deliberate overruns
    task automatic next_random(output logic op, output logic [7:0] b);
        int r, room, n;
        r  = $urandom_range(0, 99);
        op = OP_BODY;
        b  = 8'($urandom_range(0, 255));
        if (sb.halted) begin
            if (r < 70) op = OP_START;
            return;
        end
        if (r < 3) begin
            op = OP_START;
            return;
        end
        if (r < 8 || !sb.wants_code()) return;     // noise, or a data byte
        if (r < 10) begin
            b = CODE_NOP;
            return;
        end
        room = sb.room_left();
        if (room == 0) return;
        if (r < 14 && room < 128) n = $urandom_range(room + 1, 128);
        else n = $urandom_range(1, (room < 128) ? room : 128);
        if (n == 1 || $urandom_range(0, 1)) b = 8'(n - 1);   // literal code
        else b = 8'(257 - n);                               // run code
    endtask

    // -------------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------------
    initial begin : stimulus
        logic       op;
        logic [7:0] b;
        int         taken;
        int         waited;
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // small image: 4 bytes per plane row, two planes, one row
        reg_write(REG_ROW_BYTES,   32'd4);
        reg_write(REG_ROW_TOTAL,   32'd1);
        reg_write(REG_PLANE_TOTAL, 32'd2);
        reg_write(REG_PACKED_MODE, 32'd1);

        send_item(OP_BODY, 8'h00);          // literal of one
        send_item(OP_BODY, 8'h00);
        send_item(OP_BODY, 8'hFE);          // run of three
        send_item(OP_BODY, 8'hFF);          // fills plane 0
        send_item(OP_BODY, CODE_NOP);
        send_item(OP_BODY, 8'h81);          // run of 128: overrun, halts
        send_item(OP_BODY, 8'h55);          // dropped while halted
        send_item(OP_START, 8'hFF);
        send_item(OP_BODY, 8'h7F);          // literal of 128: overrun
        send_item(OP_START, 8'h00);
        send_item(OP_BODY, 8'h03);          // literal of four
        send_item(OP_BODY, 8'hAA);
        send_item(OP_BODY, 8'h01);
        send_item(OP_BODY, 8'h80);
        send_item(OP_BODY, 8'h7F);
        send_item(OP_BODY, 8'hFD);          // run of four completes the image
        send_item(OP_BODY, 8'h5A);
        send_item(OP_START, 8'($urandom_range(0, 255)));

        // row shrinks under a pending literal: next literal byte overruns
        send_item(OP_BODY, 8'h02);
        send_item(OP_BODY, 8'h11);
        wait_drained();
        reg_write(REG_ROW_BYTES, 32'd1);
        send_item(OP_BODY, 8'h22);

        // raw mode under a pending run: byte is written once, raw
        wait_drained();
        reg_write(REG_ROW_BYTES, 32'd4);
        send_item(OP_START, 8'($urandom_range(0, 255)));
        send_item(OP_BODY, 8'hFF);
        wait_drained();
        reg_write(REG_PACKED_MODE, 32'd0);
        send_item(OP_BODY, 8'hC3);
        send_item(OP_BODY, 8'h3C);
        // column now beyond the new row width: wraps on this write
        wait_drained();
        reg_write(REG_ROW_BYTES, 32'd2);
        send_item(OP_BODY, 8'h99);

        // random phases, each with fresh settings and a start transfer
        for (int k = 0; k < PHASES; k++) begin
            wait_drained();
            configure_phase(k);
            sender_eager   = (k == 3);
            receiver_eager = (k == 5);
            if (k == 3) hold_request = 1'b1;
            send_item(OP_START, 8'($urandom_range(0, 255)));
            taken = 0;
            while (taken < PER_PHASE) begin
                next_random(op, b);
                // bytes dropped while halted do not count
                if (op == OP_START || !sb.halted) taken++;
                send_item(op, b);
                if (k == 6 && taken == PER_PHASE / 2) wait_drained();
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        waited = 0;
        while (sb.pending_writes.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE) @(posedge aclk);
        if (sb.pending_writes.size() != 0) begin
            $display("ERROR: %0d expected results never arrived", sb.pending_writes.size());
            sb.mismatches++;
        end

        if (sb.mismatches == 0) begin
            $display("planar_byterun1_decoder verification clean");
        end else begin
            $display("planar_byterun1_decoder verification failed");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #15_000_000;
        $display("planar_byterun1_decoder verification failed");
        $finish;
    end

endmodule
